>>> rtl/core/audio_capture_ring_writer_core_defines.svh
// assertion macros used by the capture ring writer checker
`ifndef AUDIO_CAPTURE_RING_WRITER_CORE_DEFINES_SVH
`define AUDIO_CAPTURE_RING_WRITER_CORE_DEFINES_SVH

// same-cycle implication
`define ACRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/acrw_pkg.sv
// types and constants of the audio capture ring writer
package acrw_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned AddrW    = 22;
  localparam int unsigned CountW   = 23;
  localparam int unsigned PeakW    = 24;
  localparam int unsigned DataW    = 48;
  localparam int unsigned BytesW   = 3;
  localparam int unsigned CfgDataW = 23;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CountW-1:0] CountMax       = 23'h7F_FFFF;
  localparam logic [CountW-1:0] BufFramesReset = 23'd220500;

  localparam logic [BytesW-1:0] Bytes16Mono   = 3'd2;
  localparam logic [BytesW-1:0] Bytes24Mono   = 3'd3;
  localparam logic [BytesW-1:0] Bytes16Stereo = 3'd4;
  localparam logic [BytesW-1:0] Bytes24Stereo = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCaptureEnable = 2'd0,
    CfgDepth24       = 2'd1,
    CfgStereoStore   = 2'd2,
    CfgBufferFrames  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OpCapture = 1'b0,
    OpClear   = 1'b1
  } op_e;

  typedef struct packed {
    logic              capture_enable;
    logic              depth_24bit;
    logic              stereo_store;
    logic [CountW-1:0] buffer_frames;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0]  data;
    logic [BytesW-1:0] nbytes;
    logic [PeakW-1:0]  level;
  } frame_t;

  typedef struct packed {
    logic              write_enable;
    logic [AddrW-1:0]  write_addr;
    logic [DataW-1:0]  write_data;
    logic [BytesW-1:0] write_bytes;
    logic [PeakW-1:0]  running_peak;
    logic [AddrW-1:0]  peak_addr;
    logic              peak_valid;
    logic [CountW-1:0] fill_count;
  } result_t;

endpackage

>>> rtl/core/acrw_frame_fmt.sv
// sample truncation, mono mixdown, byte packing and frame level
module acrw_frame_fmt (
  input  acrw_pkg::cfg_t                      cfg_i,
  input  logic signed [acrw_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [acrw_pkg::SampleW-1:0] right_sample_i,
  input  logic                                mono_source_i,
  output acrw_pkg::frame_t                    frame_o
);
  import acrw_pkg::*;

  logic signed [PeakW-1:0] a;
  logic signed [PeakW-1:0] r;
  logic signed [PeakW-1:0] b;
  logic signed [PeakW:0]   sum;
  logic signed [PeakW-1:0] m;
  logic        [PeakW-1:0] mag_a;
  logic        [PeakW-1:0] mag_b;
  logic        [PeakW-1:0] mag_m;

  function automatic logic [PeakW-1:0] mag(input logic signed [PeakW-1:0] v);
    return v[PeakW-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    if (cfg_i.depth_24bit) begin
      a = left_sample_i[31:8];
      r = right_sample_i[31:8];
    end else begin
      a = {{8{left_sample_i[31]}}, left_sample_i[31:16]};
      r = {{8{right_sample_i[31]}}, right_sample_i[31:16]};
    end
    b     = mono_source_i ? a : r;
    sum   = {a[PeakW-1], a} + {b[PeakW-1], b};
    m     = mono_source_i ? a : sum[PeakW:1];
    mag_a = mag(a);
    mag_b = mag(b);
    mag_m = mag(m);

    if (cfg_i.stereo_store) begin
      frame_o.level = (mag_a > mag_b) ? mag_a : mag_b;
      if (cfg_i.depth_24bit) begin
        frame_o.data   = {b, a};
        frame_o.nbytes = Bytes24Stereo;
      end else begin
        frame_o.data   = {16'h0, b[15:0], a[15:0]};
        frame_o.nbytes = Bytes16Stereo;
      end
    end else begin
      frame_o.level = mag_m;
      if (cfg_i.depth_24bit) begin
        frame_o.data   = {24'h0, m};
        frame_o.nbytes = Bytes24Mono;
      end else begin
        frame_o.data   = {32'h0, m[15:0]};
        frame_o.nbytes = Bytes16Mono;
      end
    end
  end

endmodule

>>> rtl/core/acrw_ring_state.sv
// write position, fill count and peak hold state with per-request update
module acrw_ring_state #(
  parameter int unsigned RING_DEPTH = 4194304
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              op_i,
  input  acrw_pkg::cfg_t    cfg_i,
  input  acrw_pkg::frame_t  frame_i,
  output acrw_pkg::result_t result_o
);
  import acrw_pkg::*;

  localparam int unsigned CountLimit = (1 << CountW) - 1;
  localparam int unsigned LenMax = (RING_DEPTH < CountLimit) ? RING_DEPTH : CountLimit;
  localparam int unsigned PosW = (LenMax > 1) ? $clog2(LenMax) : 1;
  localparam logic [CountW-1:0] LenMaxC = CountW'(LenMax);

  logic [PosW-1:0]   wpos_q, wpos_d;
  logic [CountW-1:0] frames_q, frames_d;
  logic [PeakW-1:0]  peak_q, peak_d;
  logic [PosW-1:0]   peak_pos_q, peak_pos_d;
  logic              peak_valid_q, peak_valid_d;

  logic [CountW-1:0] len;
  logic [PosW-1:0]   pos;
  logic [CountW-1:0] pos_inc;
  logic [CountW-1:0] pos_ext;
  logic [CountW-1:0] peak_ext;
  logic              capture;

  always_comb begin
    if (cfg_i.buffer_frames == '0) begin
      len = CountW'(1);
    end else if (cfg_i.buffer_frames > LenMaxC) begin
      len = LenMaxC;
    end else begin
      len = cfg_i.buffer_frames;
    end
    pos     = (CountW'(wpos_q) >= len) ? '0 : wpos_q;
    pos_inc = CountW'(pos) + CountW'(1);
    pos_ext = CountW'(pos);
    capture = (op_i == OpCapture) && cfg_i.capture_enable;

    wpos_d       = wpos_q;
    frames_d     = frames_q;
    peak_d       = peak_q;
    peak_pos_d   = peak_pos_q;
    peak_valid_d = peak_valid_q;

    result_o.write_enable = 1'b0;
    result_o.write_addr   = '0;
    result_o.write_data   = '0;
    result_o.write_bytes  = '0;

    if (op_i == OpClear) begin
      wpos_d       = '0;
      frames_d     = '0;
      peak_d       = '0;
      peak_pos_d   = '0;
      peak_valid_d = 1'b0;
    end else if (capture) begin
      if (peak_valid_q && (pos == peak_pos_q)) begin
        peak_valid_d = 1'b0;
      end
      if (frame_i.level >= peak_q) begin
        peak_d       = frame_i.level;
        peak_pos_d   = pos;
        peak_valid_d = 1'b1;
      end
      wpos_d = (pos_inc >= len) ? '0 : pos_inc[PosW-1:0];
      if (frames_q < CountMax) begin
        frames_d = frames_q + 1'b1;
      end
      result_o.write_enable = 1'b1;
      result_o.write_addr   = pos_ext[AddrW-1:0];
      result_o.write_data   = frame_i.data;
      result_o.write_bytes  = frame_i.nbytes;
    end

    peak_ext              = CountW'(peak_pos_d);
    result_o.running_peak = peak_d;
    result_o.peak_addr    = peak_ext[AddrW-1:0];
    result_o.peak_valid   = peak_valid_d;
    result_o.fill_count   = (frames_d < len) ? frames_d : len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q       <= '0;
      frames_q     <= '0;
      peak_q       <= '0;
      peak_pos_q   <= '0;
      peak_valid_q <= 1'b0;
    end else if (step_i) begin
      wpos_q       <= wpos_d;
      frames_q     <= frames_d;
      peak_q       <= peak_d;
      peak_pos_q   <= peak_pos_d;
      peak_valid_q <= peak_valid_d;
    end
  end

endmodule

>>> rtl/core/audio_capture_ring_writer_core.sv
// audio capture ring writer: one frame request in, at most one store write and status out
//
// Each request is one audio frame (or a clear op) and produces exactly one result.
// A request is registered on entry, then formatted and applied to the ring state
// combinationally and registered at the output. A new request is taken every cycle
// while the output is being drained. The write position wraps at buffer_frames
// (forced to at least 1 and at most RING_DEPTH); fill_count saturates at that
// length. Results with write_enable low carry zero address, data and byte count.
// Configuration writes are taken at any time and are meant to be made while no
// request is in flight.
module audio_capture_ring_writer_core #(
  parameter int unsigned RING_DEPTH = 4194304
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [acrw_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [acrw_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic signed [acrw_pkg::SampleW-1:0]   left_sample_i,
  input  logic signed [acrw_pkg::SampleW-1:0]   right_sample_i,
  input  logic                                  mono_source_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  write_enable_o,
  output logic [acrw_pkg::AddrW-1:0]            write_addr_o,
  output logic [acrw_pkg::DataW-1:0]            write_data_o,
  output logic [acrw_pkg::BytesW-1:0]           write_bytes_o,
  output logic [acrw_pkg::PeakW-1:0]            running_peak_o,
  output logic [acrw_pkg::AddrW-1:0]            peak_addr_o,
  output logic                                  peak_valid_o,
  output logic [acrw_pkg::CountW-1:0]           fill_count_o
);
  import acrw_pkg::*;

  cfg_t cfg_q;

  logic                      in_valid_q;
  logic                      op_q;
  logic signed [SampleW-1:0] left_q;
  logic signed [SampleW-1:0] right_q;
  logic                      mono_q;

  logic    out_valid_q;
  result_t res_q;
  result_t res;
  frame_t  frame;
  logic    advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_enable <= 1'b0;
      cfg_q.depth_24bit    <= 1'b0;
      cfg_q.stereo_store   <= 1'b1;
      cfg_q.buffer_frames  <= BufFramesReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgCaptureEnable: cfg_q.capture_enable <= cfg_data_i[0];
        CfgDepth24:       cfg_q.depth_24bit    <= cfg_data_i[0];
        CfgStereoStore:   cfg_q.stereo_store   <= cfg_data_i[0];
        CfgBufferFrames:  cfg_q.buffer_frames  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_i;
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
      mono_q  <= mono_source_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  acrw_frame_fmt u_fmt (
    .cfg_i          (cfg_q),
    .left_sample_i  (left_q),
    .right_sample_i (right_q),
    .mono_source_i  (mono_q),
    .frame_o        (frame)
  );

  acrw_ring_state #(
    .RING_DEPTH (RING_DEPTH)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .op_i     (op_q),
    .cfg_i    (cfg_q),
    .frame_i  (frame),
    .result_o (res)
  );

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = res_q.write_enable;
  assign write_addr_o   = res_q.write_addr;
  assign write_data_o   = res_q.write_data;
  assign write_bytes_o  = res_q.write_bytes;
  assign running_peak_o = res_q.running_peak;
  assign peak_addr_o    = res_q.peak_addr;
  assign peak_valid_o   = res_q.peak_valid;
  assign fill_count_o   = res_q.fill_count;

endmodule

>>> rtl/core/acrw_checker.sv
// port-level assertions for the capture ring writer, bound to the top level
`include "audio_capture_ring_writer_core_defines.svh"

module acrw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          write_enable_o,
  input logic [acrw_pkg::AddrW-1:0]    write_addr_o,
  input logic [acrw_pkg::DataW-1:0]    write_data_o,
  input logic [acrw_pkg::BytesW-1:0]   write_bytes_o,
  input logic                          peak_valid_o,
  input logic [acrw_pkg::CountW-1:0]   fill_count_o
);
  import acrw_pkg::*;

  // a stalled result stays offered
  `ACRW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // a write carries one of the legal byte counts
  `ACRW_ASSERT_IMP(a_bytes_legal, clk_i, rst_ni, out_valid_o && write_enable_o, (write_bytes_o == Bytes16Mono) || (write_bytes_o == Bytes24Mono) || (write_bytes_o == Bytes16Stereo) || (write_bytes_o == Bytes24Stereo), "illegal write byte count")

  // no write means zero address, data and byte count
  `ACRW_ASSERT_IMP(a_idle_zero, clk_i, rst_ni, out_valid_o && !write_enable_o, (write_addr_o == '0) && (write_data_o == '0) && (write_bytes_o == '0), "nonzero payload without write")

  // an empty ring cannot hold a valid peak
  `ACRW_ASSERT_IMP(a_empty_no_peak, clk_i, rst_ni, out_valid_o && (fill_count_o == '0), !peak_valid_o, "peak valid with empty ring")

endmodule

bind audio_capture_ring_writer_core acrw_checker u_acrw_checker (.*);

>>> tb/testbench.sv
// testbench of the audio capture ring writer core: directed table, random phases, scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acrw_pkg::*;

  localparam int unsigned RingDepth   = 4194304;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseCount  = 12;

  typedef struct {
    bit               is_cfg;
    cfg_reg_e         reg_idx;
    logic [CfgDataW-1:0] reg_val;
    op_e              op;
    logic [31:0]      left;
    logic [31:0]      right;
    logic             mono;
    bit               typed;
    result_t          want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                op_in = 1'b0;
  logic signed [31:0]  left_in = '0;
  logic signed [31:0]  right_in = '0;
  logic                mono_in = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                we_o;
  logic [AddrW-1:0]    addr_o;
  logic [DataW-1:0]    data_o;
  logic [BytesW-1:0]   bytes_o;
  logic [PeakW-1:0]    peak_o;
  logic [AddrW-1:0]    peak_addr_o;
  logic                peak_valid_o;
  logic [CountW-1:0]   fill_o;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic cfg_fire = 1'b0;

  // shadow configuration and ring state
  logic              cap_en = 1'b0;
  logic              depth24 = 1'b0;
  logic              stereo = 1'b1;
  logic [CountW-1:0] buf_frames = BufFramesReset;
  int unsigned       wr_pos = 0;
  int unsigned       frames_cnt = 0;
  int unsigned       peak_lvl = 0;
  int unsigned       peak_pos = 0;
  bit                peak_ok = 1'b0;

  result_t     frames_due[$];
  stim_row_t   stim_table[$];
  int          idle_pct = 24;
  int unsigned cycles = 0;
  int          errors = 0;
  int          items_sent = 0;
  int          clears_sent = 0;
  int          results_seen = 0;
  int          writes_seen = 0;

  audio_capture_ring_writer_core #(
    .RING_DEPTH(RingDepth)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op_in),
    .left_sample_i (left_in),
    .right_sample_i(right_in),
    .mono_source_i (mono_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .write_enable_o(we_o),
    .write_addr_o  (addr_o),
    .write_data_o  (data_o),
    .write_bytes_o (bytes_o),
    .running_peak_o(peak_o),
    .peak_addr_o   (peak_addr_o),
    .peak_valid_o  (peak_valid_o),
    .fill_count_o  (fill_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes are sampled on the falling edge before the rising edge that takes them
  always @(negedge clk_i) begin
    in_fire  = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    cfg_fire = cfg_valid && cfg_ready;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, frames_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic result_t predict_frame(op_e op, logic signed [31:0] l,
                                            logic signed [31:0] r, logic mono);
    result_t     res;
    int unsigned len;
    int unsigned pos;
    int unsigned lvl;
    int unsigned fill;
    int          a;
    int          b;
    int          m;
    res = '0;
    len = (buf_frames == 0) ? 1 : ((buf_frames > RingDepth) ? RingDepth : buf_frames);
    if (op == OpClear) begin
      wr_pos = 0;
      frames_cnt = 0;
      peak_lvl = 0;
      peak_pos = 0;
      peak_ok = 1'b0;
    end else if (cap_en) begin
      a = depth24 ? (l >>> 8) : (l >>> 16);
      b = mono ? a : (depth24 ? (r >>> 8) : (r >>> 16));
      pos = (wr_pos >= len) ? 0 : wr_pos;
      if (peak_ok && pos == peak_pos) peak_ok = 1'b0;
      if (stereo) begin
        lvl = (magnitude(a) > magnitude(b)) ? magnitude(a) : magnitude(b);
        if (depth24) begin
          res.write_data  = {b[23:0], a[23:0]};
          res.write_bytes = Bytes24Stereo;
        end else begin
          res.write_data  = {16'h0, b[15:0], a[15:0]};
          res.write_bytes = Bytes16Stereo;
        end
      end else begin
        m = mono ? a : ((a + b) >>> 1);
        lvl = magnitude(m);
        if (depth24) begin
          res.write_data  = {24'h0, m[23:0]};
          res.write_bytes = Bytes24Mono;
        end else begin
          res.write_data  = {32'h0, m[15:0]};
          res.write_bytes = Bytes16Mono;
        end
      end
      if (lvl >= peak_lvl) begin
        peak_lvl = lvl;
        peak_pos = pos;
        peak_ok = 1'b1;
      end
      res.write_enable = 1'b1;
      res.write_addr = AddrW'(pos);
      pos++;
      if (pos >= len) pos = 0;
      wr_pos = pos;
      if (frames_cnt < CountMax) frames_cnt++;
    end
    fill = (frames_cnt < len) ? frames_cnt : len;
    res.running_peak = PeakW'(peak_lvl);
    res.peak_addr    = AddrW'(peak_pos);
    res.peak_valid   = peak_ok;
    res.fill_count   = CountW'(fill);
    return res;
  endfunction

  function automatic result_t mk_result(logic we, logic [AddrW-1:0] addr,
                                        logic [DataW-1:0] data, logic [BytesW-1:0] nbytes,
                                        logic [PeakW-1:0] peak, logic [AddrW-1:0] paddr,
                                        logic pvalid, logic [CountW-1:0] fill);
    result_t res;
    res.write_enable = we;
    res.write_addr   = addr;
    res.write_data   = data;
    res.write_bytes  = nbytes;
    res.running_peak = peak;
    res.peak_addr    = paddr;
    res.peak_valid   = pvalid;
    res.fill_count   = fill;
    return res;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.op      = OpCapture;
    row.left    = '0;
    row.right   = '0;
    row.mono    = 1'b0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic stim_row_t frame_row(op_e op, logic [31:0] l, logic [31:0] r,
                                          logic mono, bit typed, result_t want);
    stim_row_t row;
    row = cfg_row(CfgCaptureEnable, '0);
    row.is_cfg = 1'b0;
    row.op     = op;
    row.left   = l;
    row.right  = r;
    row.mono   = mono;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      4: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= 40)
      $display("result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    out_ready <= ($urandom_range(99) >= idle_pct);
    if (out_fire) begin
      results_seen++;
      if (we_o) writes_seen++;
      if (frames_due.size() == 0) begin
        report_mismatch("result with nothing pending, write_enable", we_o, 0);
      end else begin
        want = frames_due.pop_front();
        if (we_o !== want.write_enable)
          report_mismatch("write_enable", we_o, want.write_enable);
        if (addr_o !== want.write_addr) report_mismatch("write_addr", addr_o, want.write_addr);
        if (data_o !== want.write_data) report_mismatch("write_data", data_o, want.write_data);
        if (bytes_o !== want.write_bytes)
          report_mismatch("write_bytes", bytes_o, want.write_bytes);
        if (peak_o !== want.running_peak)
          report_mismatch("running_peak", peak_o, want.running_peak);
        if (peak_addr_o !== want.peak_addr)
          report_mismatch("peak_addr", peak_addr_o, want.peak_addr);
        if (peak_valid_o !== want.peak_valid)
          report_mismatch("peak_valid", peak_valid_o, want.peak_valid);
        if (fill_o !== want.fill_count) report_mismatch("fill_count", fill_o, want.fill_count);
      end
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_fire);
    cfg_valid <= 1'b0;
    case (idx)
      CfgCaptureEnable: cap_en = val[0];
      CfgDepth24:       depth24 = val[0];
      CfgStereoStore:   stereo = val[0];
      CfgBufferFrames:  buf_frames = val;
      default: ;
    endcase
  endtask

  task automatic send_frame(op_e op, logic [31:0] l, logic [31:0] r, logic mono,
                            bit typed, result_t want);
    result_t pred;
    in_valid <= 1'b1;
    op_in    <= op;
    left_in  <= l;
    right_in <= r;
    mono_in  <= mono;
    do @(posedge clk_i); while (!in_fire);
    pred = predict_frame(op, l, r, mono);
    frames_due.push_back(typed ? want : pred);
    items_sent++;
    if (op == OpClear) clears_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function automatic logic [CfgDataW-1:0] flag_value(logic bit_val);
    return {$urandom_range(0, 1) ? 22'($urandom) : 22'h0, bit_val};
  endfunction

  initial begin
    logic [CfgDataW-1:0] phase_len [PhaseCount];
    int                  n;
    op_e                 op;
    stim_row_t           row;

    phase_len = '{23'd5, 23'd1, 23'd0, 23'd17, 23'h7F_FFFF, 23'd2, 23'd33,
                  23'(RingDepth), 23'd9, 23'(RingDepth + 1), 23'd3, 23'd64};

    // reset values: capture off, 16-bit stereo, long ring
    stim_table.push_back(frame_row(OpCapture, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
                                   mk_result(1'b0, '0, '0, '0, '0, '0, 1'b0, '0)));
    stim_table.push_back(cfg_row(CfgCaptureEnable, 23'd1));
    stim_table.push_back(frame_row(OpCapture, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1,
                                   mk_result(1'b1, '0, 48'h7FFF_8000, Bytes16Stereo,
                                             24'd32768, '0, 1'b1, 23'd1)));
    stim_table.push_back(frame_row(OpCapture, 32'h0, 32'h0, 1'b0, 1'b1,
                                   mk_result(1'b1, 22'd1, '0, Bytes16Stereo, 24'd32768, '0,
                                             1'b1, 23'd2)));
    stim_table.push_back(frame_row(OpClear, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                   mk_result(1'b0, '0, '0, '0, '0, '0, 1'b0, '0)));
    stim_table.push_back(cfg_row(CfgDepth24, 23'd1));
    stim_table.push_back(frame_row(OpCapture, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
                                   mk_result(1'b1, '0, 48'h8000_007F_FFFF, Bytes24Stereo,
                                             24'h80_0000, '0, 1'b1, 23'd1)));
    stim_table.push_back(cfg_row(CfgStereoStore, 23'd0));
    // equal peak moves the peak position
    stim_table.push_back(frame_row(OpCapture, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1,
                                   mk_result(1'b1, 22'd1, 48'h80_0000, Bytes24Mono,
                                             24'h80_0000, 22'd1, 1'b1, 23'd2)));
    stim_table.push_back(frame_row(OpCapture, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b1,
                                   mk_result(1'b1, 22'd2, 48'hFF_FFFF, Bytes24Mono,
                                             24'h80_0000, 22'd1, 1'b1, 23'd3)));
    // odd negative sum rounds toward minus infinity
    stim_table.push_back(frame_row(OpCapture, 32'h0000_0100, 32'hFFFF_FE00, 1'b0, 1'b0, '0));
    stim_table.push_back(frame_row(OpCapture, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0));
    stim_table.push_back(cfg_row(CfgStereoStore, 23'd1));
    stim_table.push_back(frame_row(OpCapture, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, '0));
    stim_table.push_back(cfg_row(CfgDepth24, 23'd0));
    stim_table.push_back(cfg_row(CfgStereoStore, 23'd0));
    stim_table.push_back(frame_row(OpCapture, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b0, '0));
    stim_table.push_back(frame_row(OpCapture, 32'h7FFF_0000, 32'h7FFF_0000, 1'b0, 1'b0, '0));
    // ring shrunk below the write position, then wraps
    stim_table.push_back(cfg_row(CfgBufferFrames, 23'd3));
    stim_table.push_back(frame_row(OpCapture, 32'h0001_0000, 32'h0, 1'b1, 1'b0, '0));
    stim_table.push_back(frame_row(OpCapture, 32'hFFFE_0000, 32'h0, 1'b1, 1'b0, '0));
    stim_table.push_back(frame_row(OpCapture, 32'h0003_0000, 32'h0, 1'b1, 1'b0, '0));
    stim_table.push_back(frame_row(OpCapture, 32'h0000_FFFF, 32'h0, 1'b1, 1'b0, '0));
    // zero length behaves as one frame
    stim_table.push_back(cfg_row(CfgBufferFrames, 23'd0));
    stim_table.push_back(frame_row(OpCapture, 32'h4000_0000, 32'hC000_0000, 1'b0, 1'b0, '0));
    stim_table.push_back(frame_row(OpCapture, 32'h0, 32'h8000_0000, 1'b0, 1'b0, '0));
    stim_table.push_back(cfg_row(CfgBufferFrames, 23'h7F_FFFF));
    stim_table.push_back(frame_row(OpCapture, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '0));
    stim_table.push_back(cfg_row(CfgCaptureEnable, 23'd0));
    stim_table.push_back(frame_row(OpCapture, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0));
    stim_table.push_back(frame_row(OpClear, 32'h0, 32'h0, 1'b0, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_cfg) write_reg(row.reg_idx, row.reg_val);
      else send_frame(row.op, row.left, row.right, row.mono, row.typed, row.want);
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      idle_pct = (ph == 3) ? 0 : 24;
      write_reg(CfgCaptureEnable, flag_value(ph != 6));
      write_reg(CfgDepth24, flag_value(ph[0]));
      write_reg(CfgStereoStore, flag_value(ph[1]));
      write_reg(CfgBufferFrames, phase_len[ph]);
      n = (ph == 6) ? 40 : 130;
      for (int i = 0; i < n; i++) begin
        // hold off until the output side has drained everything
        if (ph == 4 && i == n / 2) wait_idle();
        op = ($urandom_range(99) < 3) ? OpClear : OpCapture;
        send_frame(op, rand_sample(), rand_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    wait_idle();
    $display("sent %0d requests (%0d clears) over %0d register settings", items_sent,
             clears_sent, PhaseCount + 1);
    $display("checked %0d results, %0d store writes, %0d mismatches", results_seen,
             writes_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/acrw_pkg.sv
rtl/core/acrw_frame_fmt.sv
rtl/core/acrw_ring_state.sv
rtl/core/audio_capture_ring_writer_core.sv
rtl/core/acrw_checker.sv
tb/testbench.sv
